// ----- rtl/atfb_pkg.sv -----
package atfb_pkg;

  localparam int unsigned MAX_PAYLOAD = 8;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] FRAME_TYPE = 8'h10;
  localparam logic [7:0] HEADER_LEN = 8'd16;
  localparam logic [7:0] ID_LAST    = 8'd254;
  localparam logic [7:0] MARK_DATA  = 8'h00;
  localparam logic [7:0] MARK_UNIT  = 8'hFF;

  // byte positions within the frame
  localparam int unsigned IDX_W = 5;
  localparam logic [IDX_W-1:0] IDX_START   = 5'd0;
  localparam logic [IDX_W-1:0] IDX_LEN_HI  = 5'd1;
  localparam logic [IDX_W-1:0] IDX_LEN_LO  = 5'd2;
  localparam logic [IDX_W-1:0] IDX_TYPE    = 5'd3;
  localparam logic [IDX_W-1:0] IDX_ID      = 5'd4;
  localparam logic [IDX_W-1:0] IDX_ADDR7   = 5'd5;
  localparam logic [IDX_W-1:0] IDX_ADDR6   = 5'd6;
  localparam logic [IDX_W-1:0] IDX_ADDR5   = 5'd7;
  localparam logic [IDX_W-1:0] IDX_ADDR4   = 5'd8;
  localparam logic [IDX_W-1:0] IDX_ADDR3   = 5'd9;
  localparam logic [IDX_W-1:0] IDX_ADDR2   = 5'd10;
  localparam logic [IDX_W-1:0] IDX_ADDR1   = 5'd11;
  localparam logic [IDX_W-1:0] IDX_ADDR0   = 5'd12;
  localparam logic [IDX_W-1:0] IDX_NET1    = 5'd13;
  localparam logic [IDX_W-1:0] IDX_NET0    = 5'd14;
  localparam logic [IDX_W-1:0] IDX_RADIUS  = 5'd15;
  localparam logic [IDX_W-1:0] IDX_OPTIONS = 5'd16;
  localparam logic [IDX_W-1:0] IDX_SENSOR  = 5'd17;
  localparam logic [IDX_W-1:0] IDX_MARKER  = 5'd18;
  localparam logic [IDX_W-1:0] IDX_PAYLOAD = 5'd19;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_NET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPTIONS   = 3'd3;

  typedef struct packed {
    logic [7:0]  sensor_id;
    logic        is_unit;
    logic [3:0]  payload_len;
    logic [63:0] payload;
  } in_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
  } out_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

endpackage

// ----- rtl/api_transmit_frame_builder.sv -----
// Builds one API transmit-request frame per input word and streams it out one
// byte per output word, start byte first and checksum (flagged by last) at the
// end. A payload_len above eight is taken as eight, so a frame is 20 bytes plus
// the saturated length. With out_ready held high the block captures an input
// word, then walks the frame byte counter over its bytes at one byte per cycle,
// with a single 8-bit adder accumulating the checksum and the payload held in
// a shift register; a low out_ready holds the next byte back. in_ready is low
// while a frame is being sent. Configuration writes land immediately and must
// be made only while the block is idle.
module api_transmit_frame_builder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  atfb_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output atfb_pkg::out_word_t                 out_data,
  input  logic                                cfg_we,
  input  logic [atfb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                         cfg_wdata
);

  atfb_pkg::state_t state_r, state_nxt;

  logic [63:0] dest_addr_r;
  logic [15:0] dest_net_r;
  logic [7:0]  radius_r;
  logic [7:0]  options_r;
  logic [7:0]  frame_cnt_r;

  logic [7:0]  sensor_r;
  logic        unit_r;
  logic [3:0]  len_r;
  logic [63:0] payload_r;
  logic [atfb_pkg::IDX_W-1:0] end_idx_r;

  logic [atfb_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]  sum_r, sum_nxt;

  logic        out_valid_r, out_valid_nxt;
  atfb_pkg::out_word_t out_r, out_nxt;

  logic        in_fire;
  logic        slot_free;
  logic        load;
  logic        at_end;
  logic        in_payload;
  logic        summed;
  logic [7:0]  byte_sel;
  logic [3:0]  len_sat;

  assign in_ready  = (state_r == atfb_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign load      = (state_r == atfb_pkg::ST_SEND) && slot_free;
  assign at_end    = (idx_r == end_idx_r);
  assign in_payload = (idx_r >= atfb_pkg::IDX_PAYLOAD) && !at_end;
  assign summed    = (idx_r >= atfb_pkg::IDX_TYPE) && !at_end;
  assign len_sat   = (in_data.payload_len > 4'(atfb_pkg::MAX_PAYLOAD)) ?
                     4'(atfb_pkg::MAX_PAYLOAD) : in_data.payload_len;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      atfb_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = atfb_pkg::ST_SEND;
      end
      atfb_pkg::ST_SEND: begin
        if (slot_free && at_end) state_nxt = atfb_pkg::ST_IDLE;
      end
      default: state_nxt = atfb_pkg::ST_IDLE;
    endcase
  end

  // byte select
  always_comb begin
    unique case (idx_r)
      atfb_pkg::IDX_START:   byte_sel = atfb_pkg::START_BYTE;
      atfb_pkg::IDX_LEN_HI:  byte_sel = 8'h00;
      atfb_pkg::IDX_LEN_LO:  byte_sel = atfb_pkg::HEADER_LEN + {4'h0, len_r};
      atfb_pkg::IDX_TYPE:    byte_sel = atfb_pkg::FRAME_TYPE;
      atfb_pkg::IDX_ID:      byte_sel = frame_cnt_r;
      atfb_pkg::IDX_ADDR7:   byte_sel = dest_addr_r[63:56];
      atfb_pkg::IDX_ADDR6:   byte_sel = dest_addr_r[55:48];
      atfb_pkg::IDX_ADDR5:   byte_sel = dest_addr_r[47:40];
      atfb_pkg::IDX_ADDR4:   byte_sel = dest_addr_r[39:32];
      atfb_pkg::IDX_ADDR3:   byte_sel = dest_addr_r[31:24];
      atfb_pkg::IDX_ADDR2:   byte_sel = dest_addr_r[23:16];
      atfb_pkg::IDX_ADDR1:   byte_sel = dest_addr_r[15:8];
      atfb_pkg::IDX_ADDR0:   byte_sel = dest_addr_r[7:0];
      atfb_pkg::IDX_NET1:    byte_sel = dest_net_r[15:8];
      atfb_pkg::IDX_NET0:    byte_sel = dest_net_r[7:0];
      atfb_pkg::IDX_RADIUS:  byte_sel = radius_r;
      atfb_pkg::IDX_OPTIONS: byte_sel = options_r;
      atfb_pkg::IDX_SENSOR:  byte_sel = sensor_r;
      atfb_pkg::IDX_MARKER:  byte_sel = unit_r ? atfb_pkg::MARK_UNIT : atfb_pkg::MARK_DATA;
      default:               byte_sel = at_end ? ~sum_r : payload_r[7:0];
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    idx_nxt       = idx_r;
    sum_nxt       = sum_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      atfb_pkg::ST_IDLE: begin
        if (in_valid) begin
          idx_nxt = atfb_pkg::IDX_START;
          sum_nxt = 8'h00;
        end
      end
      atfb_pkg::ST_SEND: begin
        if (load) begin
          out_nxt.frame_byte = byte_sel;
          out_nxt.last       = at_end;
          out_valid_nxt      = 1'b1;
          idx_nxt            = idx_r + 1'b1;
          if (summed) sum_nxt = sum_r + byte_sel;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atfb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      frame_cnt_r <= 8'h00;
      dest_addr_r <= 64'h0;
      dest_net_r  <= 16'h0;
      radius_r    <= 8'h00;
      options_r   <= 8'h00;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (load && at_end) begin
        frame_cnt_r <= (frame_cnt_r == atfb_pkg::ID_LAST) ? 8'h00 : frame_cnt_r + 8'd1;
      end
      if (cfg_we) begin
        case (cfg_index)
          atfb_pkg::REG_DEST_ADDR: dest_addr_r <= cfg_wdata;
          atfb_pkg::REG_DEST_NET:  dest_net_r  <= cfg_wdata[15:0];
          atfb_pkg::REG_RADIUS:    radius_r    <= cfg_wdata[7:0];
          atfb_pkg::REG_OPTIONS:   options_r   <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // payload path: capture, then shift one byte out per payload word
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    sum_r <= sum_nxt;
    out_r <= out_nxt;
    if (in_fire) begin
      sensor_r  <= in_data.sensor_id;
      unit_r    <= in_data.is_unit;
      len_r     <= len_sat;
      payload_r <= in_data.payload;
      end_idx_r <= atfb_pkg::IDX_PAYLOAD + {1'b0, len_sat};
    end else if (load && in_payload) begin
      payload_r <= {8'h00, payload_r[63:8]};
    end
  end

  a_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == atfb_pkg::ST_SEND |-> idx_r <= end_idx_r)
    else $error("byte counter ran past the checksum position");

  a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    frame_cnt_r != 8'hFF)
    else $error("frame id reached the reserved value");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == atfb_pkg::ST_SEND && idx_r == atfb_pkg::IDX_START
                && sum_r == 8'h00)
    else $error("frame did not start cleanly");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    load && at_end |=> state_r == atfb_pkg::ST_IDLE && out_valid_r && out_r.last)
    else $error("checksum word not flagged or sequencer not idle");

  a_last_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    load && !at_end |=> !out_r.last)
    else $error("last flagged before the checksum");

endmodule
